@@ hdl/tcfr_pkg.sv @@
// Shared types, codes and the 6x8 font table of the text cell frame renderer.
// Used by every module of the block but tcfr_ram; depends on nothing.
`timescale 1ns / 1ps
package tcfr_pkg;

  localparam int GLYPH_WIDTH = 6;
  localparam int GLYPH_COUNT = 96;
  localparam logic [7:0] FIRST_CODE = 8'h20;

  typedef enum logic [1:0] {
    ACT_DRAW   = 2'd0,
    ACT_INVERT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_POS  = 2'd1,
    STAT_BAD_CODE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] row;
    logic [3:0] cell_req;
    logic [7:0] char_code;
    logic       inverse;
    logic [8:0] read_address;
  } tcfr_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
  } tcfr_out_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DRAW,
    ST_INV_FIRST,
    ST_INV_RUN,
    ST_INV_LAST,
    ST_CLEAR,
    ST_RD_ADDR,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    WR_ZERO,
    WR_GLYPH,
    WR_INV
  } wr_sel_t;

  typedef enum logic {
    RD_INV,
    RD_REQ
  } rd_sel_t;

  typedef struct packed {
    logic    load_req;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    load_out;
  } tcfr_cmd_t;

  typedef struct packed {
    action_t act;
    status_t chk;
    logic    draw_last;
    logic    row_last;
    logic    store_last;
  } tcfr_sts_t;

  // Glyph bytes in column order, leftmost column in the top byte.
  localparam logic [8*GLYPH_WIDTH-1:0] FONT_ROM [GLYPH_COUNT] = '{
    48'h000000000000, 48'h00005f000000, 48'h000700070000, 48'h147f147f1400,
    48'h242a7f2a1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
    48'h001c22410000, 48'h0041221c0000, 48'h14083e081400, 48'h08083e080800,
    48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
    48'h3e5149453e00, 48'h00427f400000, 48'h426151494600, 48'h2141454b3100,
    48'h1814127f1000, 48'h274545453900, 48'h3c4a49493000, 48'h017109050300,
    48'h364949493600, 48'h064949291e00, 48'h003636000000, 48'h005636000000,
    48'h081422410000, 48'h141414141400, 48'h004122140800, 48'h020151090600,
    48'h324979413e00, 48'h7e1111117e00, 48'h7f4949493600, 48'h3e4141412200,
    48'h7f4141221c00, 48'h7f4949494100, 48'h7f0909090100, 48'h3e4149497a00,
    48'h7f0808087f00, 48'h00417f410000, 48'h2040413f0100, 48'h7f0814224100,
    48'h7f4040404000, 48'h7f020c027f00, 48'h7f0408107f00, 48'h3e4141413e00,
    48'h7f0909090600, 48'h3e4151215e00, 48'h7f0919294600, 48'h464949493100,
    48'h01017f010100, 48'h3f4040403f00, 48'h1f2040201f00, 48'h3f4038403f00,
    48'h631408146300, 48'h070870080700, 48'h615149454300, 48'h007f41410000,
    48'h020408102000, 48'h0041417f0000, 48'h040201020400, 48'h404040404000,
    48'h000102040000, 48'h205454547800, 48'h7f4844443800, 48'h384444442000,
    48'h384444487f00, 48'h385454541800, 48'h087e09010200, 48'h0c5252523e00,
    48'h7f0804047800, 48'h00447d400000, 48'h2040443d0000, 48'h7f1028440000,
    48'h00417f400000, 48'h7c0418047800, 48'h7c0804047800, 48'h384444443800,
    48'h7c1414140800, 48'h081414187c00, 48'h7c0804040800, 48'h485454542000,
    48'h043f44402000, 48'h3c4040207c00, 48'h1c2040201c00, 48'h3c4030403c00,
    48'h442810284400, 48'h0c5050503c00, 48'h4464544c4400, 48'h000836410000,
    48'h00007f000000, 48'h004136080000, 48'h100808100800, 48'h784641467800
  };

endpackage

@@ hdl/tcfr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module tcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/tcfr_ctrl.sv @@
// Controller of the text cell frame renderer: request sequencing and result handshake.
// Depends on tcfr_pkg.
`timescale 1ns / 1ps
module tcfr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tcfr_pkg::tcfr_sts_t sts,
  output tcfr_pkg::tcfr_cmd_t cmd
);
  import tcfr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    cmd.wr_sel    = WR_ZERO;
    cmd.rd_sel    = RD_INV;
    in_ready      = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_ZERO;
        cmd.cnt_inc = 1'b1;
        if (sts.store_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          cmd.cnt_clr  = 1'b1;
          case (sts.act)
            ACT_DRAW:   state_nxt = (sts.chk == STAT_OK) ? ST_DRAW : ST_RESP;
            ACT_INVERT: state_nxt = (sts.chk == STAT_OK) ? ST_INV_FIRST : ST_RESP;
            ACT_CLEAR:  state_nxt = ST_CLEAR;
            ACT_READ:   state_nxt = (sts.chk == STAT_OK) ? ST_RD_ADDR : ST_RESP;
            default:    state_nxt = ST_RESP;
          endcase
        end
      end
      ST_DRAW: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_GLYPH;
        cmd.cnt_inc = 1'b1;
        if (sts.draw_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_INV_FIRST: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_INV;
        cmd.cnt_inc = 1'b1;
        state_nxt   = ST_INV_RUN;
      end
      ST_INV_RUN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_INV;
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_INV;
        cmd.cnt_inc = 1'b1;
        if (sts.row_last) begin
          state_nxt = ST_INV_LAST;
        end
      end
      ST_INV_LAST: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_INV;
        state_nxt  = ST_RESP;
      end
      ST_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_ZERO;
        cmd.cnt_inc = 1'b1;
        if (sts.store_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RD_ADDR: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_REQ;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ hdl/tcfr_dp.sv @@
// Datapath of the text cell frame renderer: request checks, address counter,
// frame store and result register. Depends on tcfr_pkg and tcfr_ram.
`timescale 1ns / 1ps
module tcfr_dp #(
  parameter int ROW_BYTES     = 84,
  parameter int TEXT_ROWS     = 6,
  parameter int CELLS_PER_ROW = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcfr_pkg::tcfr_in_t  in_data,
  output tcfr_pkg::tcfr_out_t out_data,
  input  tcfr_pkg::tcfr_cmd_t cmd,
  output tcfr_pkg::tcfr_sts_t sts
);
  import tcfr_pkg::*;

  localparam int STORE_BYTES = TEXT_ROWS * ROW_BYTES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CW          = $clog2(STORE_BYTES + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] base_r, base_nxt;
  action_t       act_r;
  status_t       stat_r;
  logic [6:0]    glyph_r;
  logic          inverse_r;
  logic [AW-1:0] raddr_req_r;
  tcfr_out_t     out_r;

  action_t       in_act;
  logic          row_ok, cell_ok, code_ok, addr_ok;
  status_t       chk;
  logic [AW-1:0] row_base, cell_off;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata, glyph_byte;
  logic [2:0]    col;

  always_comb begin
    in_act  = action_t'(in_data.action);
    row_ok  = int'(in_data.row) < TEXT_ROWS;
    cell_ok = (int'(in_data.cell_req) < CELLS_PER_ROW) &&
              ((int'(in_data.cell_req) + 1) * GLYPH_WIDTH <= ROW_BYTES);
    code_ok = (in_data.char_code >= FIRST_CODE) && !in_data.char_code[7];
    addr_ok = int'(in_data.read_address) < STORE_BYTES;
    case (in_act)
      ACT_DRAW: begin
        if (!(row_ok && cell_ok)) begin
          chk = STAT_BAD_POS;
        end else if (!code_ok) begin
          chk = STAT_BAD_CODE;
        end else begin
          chk = STAT_OK;
        end
      end
      ACT_INVERT: chk = row_ok ? STAT_OK : STAT_BAD_POS;
      ACT_READ:   chk = addr_ok ? STAT_OK : STAT_BAD_POS;
      default:    chk = STAT_OK;
    endcase
    row_base = AW'(int'(in_data.row) * ROW_BYTES);
    cell_off = (in_act == ACT_DRAW) ? AW'(int'(in_data.cell_req) * GLYPH_WIDTH) : '0;
    base_nxt = row_base + cell_off;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      act_r       <= in_act;
      stat_r      <= chk;
      base_r      <= base_nxt;
      glyph_r     <= in_data.char_code[6:0] - FIRST_CODE[6:0];
      inverse_r   <= in_data.inverse;
      raddr_req_r <= AW'(in_data.read_address);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign sts.act        = in_act;
  assign sts.chk        = chk;
  assign sts.draw_last  = cnt_r == CW'(GLYPH_WIDTH - 1);
  assign sts.row_last   = cnt_r == CW'(ROW_BYTES - 1);
  assign sts.store_last = cnt_r == CW'(STORE_BYTES - 1);

  always_comb begin
    col        = cnt_r[2:0];
    glyph_byte = FONT_ROM[glyph_r][(GLYPH_WIDTH - 1 - int'(col)) * 8 +: 8];
    case (cmd.wr_sel)
      WR_ZERO: begin
        waddr = AW'(cnt_r);
        wdata = '0;
      end
      WR_GLYPH: begin
        waddr = AW'(CW'(base_r) + cnt_r);
        wdata = glyph_byte ^ {8{inverse_r}};
      end
      WR_INV: begin
        waddr = AW'(CW'(base_r) + cnt_r - CW'(1));
        wdata = ~rdata;
      end
      default: begin
        waddr = AW'(cnt_r);
        wdata = '0;
      end
    endcase
    case (cmd.rd_sel)
      RD_INV:  raddr = AW'(CW'(base_r) + cnt_r);
      RD_REQ:  raddr = raddr_req_r;
      default: raddr = raddr_req_r;
    endcase
  end

  tcfr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.read_data <= (act_r == ACT_READ && stat_r == STAT_OK) ? rdata : 8'h00;
      out_r.status    <= stat_r;
    end
  end

  assign out_data = out_r;

endmodule

@@ hdl/text_cell_frame_renderer_core.sv @@
// Text cell frame renderer: 6x8 glyph drawing into a byte-strip frame store.
// Per request, a draw writes the glyph bytes of its cell, an invert row reads and
// writes back every byte of the row, a clear zeroes the whole store and a read
// fetches one byte; a rejected request goes straight to its result. One request
// in flight; a new one is taken while the previous result waits. After reset
// the store is swept to zero with in_ready low.
`timescale 1ns / 1ps
module text_cell_frame_renderer_core #(
  parameter int ROW_BYTES     = 84,
  parameter int TEXT_ROWS     = 6,
  parameter int CELLS_PER_ROW = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcfr_pkg::tcfr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcfr_pkg::tcfr_out_t out_data
);
  import tcfr_pkg::*;

  tcfr_cmd_t cmd;
  tcfr_sts_t sts;

  tcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcfr_dp #(
    .ROW_BYTES    (ROW_BYTES),
    .TEXT_ROWS    (TEXT_ROWS),
    .CELLS_PER_ROW(CELLS_PER_ROW)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .out_data(out_data),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

@@ bench/tcfr_reply_checker.sv @@
// Reply checker for the text cell frame renderer: mirrors the frame store,
// predicts each reply from accepted requests and compares it field by field.
// Depends on tcfr_pkg for the payload types, action/status codes and font table.
`timescale 1ns / 1ps
module tcfr_reply_checker #(
  parameter int ROW_BYTES     = 84,
  parameter int TEXT_ROWS     = 6,
  parameter int CELLS_PER_ROW = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  tcfr_pkg::tcfr_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  tcfr_pkg::tcfr_out_t out_data,
  output int                  fail_count,
  output int                  pending,
  output int                  replies_seen
);
  import tcfr_pkg::*;

  localparam int STORE_BYTES = ROW_BYTES * TEXT_ROWS;

  logic [7:0] frame_img [STORE_BYTES];
  tcfr_out_t  reply_queue [$];
  tcfr_out_t  want;

  initial begin
    fail_count   = 0;
    pending      = 0;
    replies_seen = 0;
  end

  function automatic tcfr_out_t apply_request(tcfr_in_t r);
    tcfr_out_t  rep;
    int         base;
    int         glyph;
    logic [7:0] flip;
    rep = '0;
    case (action_t'(r.action))
      ACT_DRAW: begin
        if (int'(r.row) >= TEXT_ROWS || int'(r.cell_req) >= CELLS_PER_ROW ||
            int'(r.cell_req) * GLYPH_WIDTH + GLYPH_WIDTH > ROW_BYTES) begin
          rep.status = STAT_BAD_POS;
        end else if (int'(r.char_code) < int'(FIRST_CODE) ||
                     int'(r.char_code) >= int'(FIRST_CODE) + GLYPH_COUNT) begin
          rep.status = STAT_BAD_CODE;
        end else begin
          base  = int'(r.row) * ROW_BYTES + int'(r.cell_req) * GLYPH_WIDTH;
          glyph = int'(r.char_code) - int'(FIRST_CODE);
          flip  = r.inverse ? 8'hFF : 8'h00;
          for (int k = 0; k < GLYPH_WIDTH; k++) begin
            frame_img[base + k] = FONT_ROM[glyph][(GLYPH_WIDTH - 1 - k) * 8 +: 8] ^ flip;
          end
        end
      end
      ACT_INVERT: begin
        if (int'(r.row) >= TEXT_ROWS) begin
          rep.status = STAT_BAD_POS;
        end else begin
          base = int'(r.row) * ROW_BYTES;
          for (int k = 0; k < ROW_BYTES; k++) begin
            frame_img[base + k] = ~frame_img[base + k];
          end
        end
      end
      ACT_CLEAR: begin
        for (int k = 0; k < STORE_BYTES; k++) begin
          frame_img[k] = 8'h00;
        end
      end
      default: begin
        if (int'(r.read_address) < STORE_BYTES) begin
          rep.read_data = frame_img[r.read_address];
        end else begin
          rep.status = STAT_BAD_POS;
        end
      end
    endcase
    return rep;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STORE_BYTES; k++) begin
        frame_img[k] = 8'h00;
      end
      reply_queue.delete();
    end else begin
      // retire the older reply before queuing the new request
      if (out_valid && out_ready) begin
        replies_seen++;
        if (reply_queue.size() == 0) begin
          $error("unexpected reply: read_data %0h status %0d", out_data.read_data,
                 out_data.status);
          fail_count++;
        end else begin
          want = reply_queue.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, out_data.read_data);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        reply_queue.push_back(apply_request(in_data));
      end
    end
    pending = reply_queue.size();
  end

endmodule

@@ bench/text_cell_frame_renderer_core_tb.sv @@
// Testbench top for text_cell_frame_renderer_core: drives directed and random
// requests with random idle bursts and reports the verdict of tcfr_reply_checker.
// Depends on tcfr_pkg, the block and bench/tcfr_reply_checker.sv.
`timescale 1ns / 1ps
module text_cell_frame_renderer_core_tb;
  import tcfr_pkg::*;

  localparam int ROW_BYTES     = 84;
  localparam int TEXT_ROWS     = 6;
  localparam int CELLS_PER_ROW = 14;
  localparam int STORE_BYTES   = ROW_BYTES * TEXT_ROWS;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int QUIET_FROM    = 1650;
  localparam int DRAIN_CYCLES  = STORE_BYTES + 16;
  localparam int CYCLE_LIMIT   = 3_200_000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  tcfr_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tcfr_out_t out_data;

  logic in_acc;
  logic idle_en = 1'b1;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;
  int   replies_seen;
  int   sent_total = 0;
  int   sent_by_action [4] = '{0, 0, 0, 0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_cell_frame_renderer_core #(
    .ROW_BYTES    (ROW_BYTES),
    .TEXT_ROWS    (TEXT_ROWS),
    .CELLS_PER_ROW(CELLS_PER_ROW)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  tcfr_reply_checker #(
    .ROW_BYTES    (ROW_BYTES),
    .TEXT_ROWS    (TEXT_ROWS),
    .CELLS_PER_ROW(CELLS_PER_ROW)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .replies_seen(replies_seen)
  );

  always @(posedge clk) begin
    in_acc <= in_valid && in_ready;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // hold out_ready low for random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic tcfr_in_t noise_req();
    return tcfr_in_t'(27'($urandom));
  endfunction

  function automatic tcfr_in_t make_req(action_t act, int row, int cell_idx, int code, bit inv,
                                        int addr);
    tcfr_in_t r;
    r.action       = act;
    r.row          = 3'(row);
    r.cell_req     = 4'(cell_idx);
    r.char_code    = 8'(code);
    r.inverse      = inv;
    r.read_address = 9'(addr);
    return r;
  endfunction

  function automatic tcfr_in_t rand_req();
    tcfr_in_t r;
    int       pick;
    r    = noise_req();
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      r.action    = ACT_DRAW;
      r.row       = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
      r.cell_req  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(14, 15))
                                                : 4'($urandom_range(0, 13));
      r.char_code = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(32, 127));
    end else if (pick < 60) begin
      r.action = ACT_INVERT;
      r.row    = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
    end else if (pick < 62) begin
      r.action = ACT_CLEAR;
    end else begin
      r.action       = ACT_READ;
      r.read_address = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                   : 9'($urandom_range(0, STORE_BYTES - 1));
    end
    return r;
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(tcfr_in_t r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(negedge clk); while (!in_acc);
    sent_total++;
    sent_by_action[r.action]++;
  endtask

  initial begin
    tcfr_in_t r;
    int       row;
    int       cell0;
    int       len;
    int       reads;
    bit       inv;
    int       random_sent;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty store, store edges, every action and every rejection
    send_req(make_req(ACT_READ, 0, 0, 0, 0, 0));
    send_req(make_req(ACT_READ, 7, 15, 255, 1, STORE_BYTES - 1));
    send_req(make_req(ACT_READ, 0, 0, 0, 0, STORE_BYTES));
    send_req(make_req(ACT_READ, 0, 0, 0, 0, 511));
    send_req(make_req(ACT_DRAW, 0, 0, 8'h41, 0, 0));
    send_req(make_req(ACT_READ, 0, 0, 0, 0, 0));
    send_req(make_req(ACT_READ, 0, 0, 0, 0, 5));
    send_req(make_req(ACT_DRAW, 5, 13, 8'h7F, 1, 511));
    send_req(make_req(ACT_READ, 0, 0, 0, 0, STORE_BYTES - 1));
    send_req(make_req(ACT_READ, 0, 0, 0, 0, STORE_BYTES - 2));
    send_req(make_req(ACT_DRAW, 2, 7, 8'h20, 1, 0));
    send_req(make_req(ACT_DRAW, 1, 3, 8'h1F, 0, 0));
    send_req(make_req(ACT_DRAW, 1, 3, 8'h80, 1, 0));
    send_req(make_req(ACT_DRAW, 1, 3, 8'hFF, 0, 0));
    send_req(make_req(ACT_DRAW, 1, 3, 8'h00, 0, 0));
    send_req(make_req(ACT_DRAW, 6, 0, 8'h41, 0, 0));
    send_req(make_req(ACT_DRAW, 7, 0, 8'h00, 0, 0));
    send_req(make_req(ACT_DRAW, 0, 14, 8'h41, 0, 0));
    send_req(make_req(ACT_DRAW, 0, 15, 8'hFF, 1, 0));
    send_req(make_req(ACT_INVERT, 0, 0, 0, 0, 0));
    send_req(make_req(ACT_INVERT, 5, 15, 255, 1, 511));
    send_req(make_req(ACT_INVERT, 6, 0, 0, 0, 0));
    send_req(make_req(ACT_INVERT, 7, 0, 0, 0, 0));
    send_req(make_req(ACT_READ, 0, 0, 0, 0, ROW_BYTES - 1));
    send_req(make_req(ACT_CLEAR, 7, 15, 255, 1, 511));
    send_req(make_req(ACT_READ, 0, 0, 0, 0, 0));

    // random: mostly strings drawn along a row and read back, plus loose requests
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      idle_en = (random_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        row   = $urandom_range(0, TEXT_ROWS - 1);
        cell0 = $urandom_range(0, CELLS_PER_ROW - 1);
        len   = $urandom_range(1, CELLS_PER_ROW - cell0);
        inv   = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++) begin
          r           = noise_req();
          r.action    = ACT_DRAW;
          r.row       = 3'(row);
          r.cell_req  = 4'(cell0 + i);
          r.char_code = 8'($urandom_range(32, 127));
          r.inverse   = inv;
          send_req(r);
          random_sent++;
        end
        reads = $urandom_range(1, 6);
        for (int i = 0; i < reads; i++) begin
          r              = noise_req();
          r.action       = ACT_READ;
          r.read_address = 9'(row * ROW_BYTES + cell0 * GLYPH_WIDTH +
                              $urandom_range(0, len * GLYPH_WIDTH - 1));
          send_req(r);
          random_sent++;
        end
      end else begin
        send_req(rand_req());
        random_sent++;
      end
    end
    in_valid <= 1'b0;
    idle_en = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d requests: %0d draw, %0d invert-row, %0d clear, %0d read",
             sent_total, sent_by_action[ACT_DRAW], sent_by_action[ACT_INVERT],
             sent_by_action[ACT_CLEAR], sent_by_action[ACT_READ]);
    $display("checked %0d replies, %0d mismatches", replies_seen, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
